@@ rtl/mdp_pkg.sv @@
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared types and constants for the method descriptor parser.
// ----------------------------------------------------------------------------
package mdp_pkg;

   localparam int unsigned POS_W  = 16;
   localparam int unsigned DIMS_W = 8;
   localparam int unsigned BASE_W = 4;

   localparam logic [POS_W-1:0]  MAX_LEN  = 16'd65535;
   localparam logic [DIMS_W-1:0] MAX_DIMS = 8'd255;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_VOID   = 8'h56;
   localparam logic [7:0] CH_OBJ    = 8'h4C;
   localparam logic [7:0] CH_ARRAY  = 8'h5B;
   localparam logic [7:0] CH_BYTE   = 8'h42;
   localparam logic [7:0] CH_CHAR   = 8'h43;
   localparam logic [7:0] CH_DOUBLE = 8'h44;
   localparam logic [7:0] CH_FLOAT  = 8'h46;
   localparam logic [7:0] CH_INT    = 8'h49;
   localparam logic [7:0] CH_LONG   = 8'h4A;
   localparam logic [7:0] CH_SHORT  = 8'h53;
   localparam logic [7:0] CH_BOOL   = 8'h5A;

   localparam logic [BASE_W-1:0] BT_BYTE   = 4'd0;
   localparam logic [BASE_W-1:0] BT_CHAR   = 4'd1;
   localparam logic [BASE_W-1:0] BT_DOUBLE = 4'd2;
   localparam logic [BASE_W-1:0] BT_FLOAT  = 4'd3;
   localparam logic [BASE_W-1:0] BT_INT    = 4'd4;
   localparam logic [BASE_W-1:0] BT_LONG   = 4'd5;
   localparam logic [BASE_W-1:0] BT_SHORT  = 4'd6;
   localparam logic [BASE_W-1:0] BT_BOOL   = 4'd7;
   localparam logic [BASE_W-1:0] BT_OBJECT = 4'd8;
   localparam logic [BASE_W-1:0] BT_VOID   = 4'd9;

   typedef enum logic [1:0] {
      PH_OPEN   = 2'd0,
      PH_PARAMS = 2'd1,
      PH_RET    = 2'd2,
      PH_END    = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic              inside_object;
      logic [DIMS_W-1:0] bracket_count;
      logic [POS_W-1:0]  token_begin;
      logic [POS_W-1:0]  byte_position;
      logic              error_seen;
   } mdp_state_type;

   localparam mdp_state_type STATE_RESET = '{
      phase:         PH_OPEN,
      inside_object: 1'b0,
      bracket_count: '0,
      token_begin:   '0,
      byte_position: '0,
      error_seen:    1'b0
   };

   typedef struct packed {
      logic              token_valid;
      logic              token_is_return;
      logic [BASE_W-1:0] base_type;
      logic [DIMS_W-1:0] array_dims;
      logic [POS_W-1:0]  token_start;
      logic [POS_W-1:0]  token_length;
      logic              done_res;
      logic              status;
   } mdp_rsp_type;

   // bit 4: primitive hit, bits 3:0: base type code
   function automatic logic [BASE_W:0] prim_lookup(input logic [7:0] b);
      logic [BASE_W:0] r;
      case (b)
         CH_BYTE:   r = {1'b1, BT_BYTE};
         CH_CHAR:   r = {1'b1, BT_CHAR};
         CH_DOUBLE: r = {1'b1, BT_DOUBLE};
         CH_FLOAT:  r = {1'b1, BT_FLOAT};
         CH_INT:    r = {1'b1, BT_INT};
         CH_LONG:   r = {1'b1, BT_LONG};
         CH_SHORT:  r = {1'b1, BT_SHORT};
         CH_BOOL:   r = {1'b1, BT_BOOL};
         default:   r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/mdp_step.sv @@
// ----------------------------------------------------------------------------
// mdp_step
// Per-byte grammar check: next parser state and the result for one byte.
// ----------------------------------------------------------------------------
module mdp_step
   import mdp_pkg::*;
(
   input  mdp_state_type st,
   input  logic [7:0]    data_byte,
   input  logic          last,
   output mdp_state_type st_next,
   output mdp_rsp_type   rsp,
   output logic          has_rsp
);

   logic              err;
   logic              tok;
   logic [BASE_W-1:0] tbase;
   logic [BASE_W:0]   prim;
   logic [POS_W:0]    empty_pos;
   mdp_state_type     nxt;

   assign prim      = prim_lookup(data_byte);
   assign empty_pos = {1'b0, st.token_begin} + {{(POS_W+1-DIMS_W){1'b0}}, st.bracket_count}
                      + {{POS_W{1'b0}}, 1'b1};

   always_comb begin
      err   = 1'b0;
      tok   = 1'b0;
      tbase = '0;
      nxt   = st;
      rsp   = '0;

      if (!st.error_seen) begin
         if (st.byte_position >= MAX_LEN) begin
            err = 1'b1;
         end else begin
            case (st.phase)
               PH_OPEN: begin
                  if (data_byte == CH_LPAREN) nxt.phase = PH_PARAMS;
                  else err = 1'b1;
               end
               PH_PARAMS, PH_RET: begin
                  if (st.inside_object) begin
                     if (data_byte == CH_NUL) begin
                        err = 1'b1;
                     end else if (data_byte == CH_SEMI) begin
                        if ({1'b0, st.byte_position} == empty_pos) begin
                           err = 1'b1;
                        end else begin
                           tok   = 1'b1;
                           tbase = BT_OBJECT;
                        end
                     end
                  end else if (data_byte == CH_RPAREN && st.phase == PH_PARAMS
                               && st.bracket_count == '0) begin
                     nxt.phase = PH_RET;
                  end else if (data_byte == CH_VOID && st.phase == PH_RET
                               && st.bracket_count == '0) begin
                     nxt.token_begin = st.byte_position;
                     tok   = 1'b1;
                     tbase = BT_VOID;
                  end else if (data_byte == CH_ARRAY) begin
                     if (st.bracket_count >= MAX_DIMS) begin
                        err = 1'b1;
                     end else begin
                        if (st.bracket_count == '0) nxt.token_begin = st.byte_position;
                        nxt.bracket_count = st.bracket_count + 8'd1;
                     end
                  end else if (data_byte == CH_OBJ) begin
                     if (st.bracket_count == '0) nxt.token_begin = st.byte_position;
                     nxt.inside_object = 1'b1;
                  end else if (prim[BASE_W]) begin
                     if (st.bracket_count == '0) nxt.token_begin = st.byte_position;
                     tok   = 1'b1;
                     tbase = prim[BASE_W-1:0];
                  end else begin
                     err = 1'b1;
                  end
               end
               default: err = 1'b1;
            endcase
         end
      end

      if (err) begin
         nxt.error_seen = 1'b1;
         tok = 1'b0;
      end

      if (tok) begin
         rsp.token_valid     = 1'b1;
         rsp.token_is_return = (st.phase == PH_RET);
         rsp.base_type       = tbase;
         rsp.array_dims      = st.bracket_count;
         rsp.token_start     = nxt.token_begin;
         rsp.token_length    = st.byte_position - nxt.token_begin + 16'd1;
         if (st.phase == PH_RET) nxt.phase = PH_END;
         nxt.bracket_count = '0;
         nxt.inside_object = 1'b0;
      end

      if (st.byte_position != {POS_W{1'b1}}) nxt.byte_position = st.byte_position + 16'd1;

      rsp.done_res = last;
      rsp.status   = last & (nxt.error_seen | (nxt.phase != PH_END));

      st_next = last ? STATE_RESET : nxt;
   end

   assign has_rsp = tok | last;

endmodule

@@ rtl/mdp_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// mdp_rsp_reg
// Result register and packing onto the master-side stream.
// ----------------------------------------------------------------------------
module mdp_rsp_reg
   import mdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  mdp_rsp_type rsp_in,
   output logic        free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // base_type, array_dims, token_start, token_length, status
   output logic [1:0]  rsp_tuser,  // token_valid, token_is_return
   output logic        rsp_tlast   // done_res
);

   logic        valid_ff, valid_in;
   mdp_rsp_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= rsp_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, data_ff.status, data_ff.token_length, data_ff.token_start,
                        data_ff.array_dims, data_ff.base_type};
   assign rsp_tuser  = {data_ff.token_is_return, data_ff.token_valid};
   assign rsp_tlast  = data_ff.done_res;

endmodule

@@ rtl/method_descriptor_parser.sv @@
// ----------------------------------------------------------------------------
// method_descriptor_parser
// Streaming checker and tokenizer for method descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one descriptor byte per transaction, req_tlast on the final byte.
//   rsp_*  : one transaction per completed type token and one for the final
//            byte; a token completing on the final byte shares that transaction.
//            rsp_tlast marks the final one, which carries the status bit.
//   Registers: a byte's result reaches rsp_* from the result register; the
//   step logic works from the input register into the result register.
//   Throughput: one byte per cycle while the result register is free.
//   Reset: synchronous; parser returns to the start of a descriptor at offset 0
//   and both registers empty. After each final byte the parser also restarts.
//   Stall: while rsp_tready is low a pending result is held; the input register
//   still takes one more byte, then req_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module method_descriptor_parser
   import mdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // base_type, array_dims, token_start, token_length, status
   output logic [1:0]  rsp_tuser,  // token_valid, token_is_return
   output logic        rsp_tlast   // done_res
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   mdp_state_type state_ff, state_in;
   mdp_state_type step_next;
   mdp_rsp_type   step_rsp;
   logic          step_has_rsp;
   logic          rsp_free;
   logic          advance;
   logic          req_take;

   assign advance     = in_valid_ff && rsp_free;
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign state_in    = advance ? step_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   mdp_step u_step (
      .st        (state_ff),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .st_next   (step_next),
      .rsp       (step_rsp),
      .has_rsp   (step_has_rsp)
   );

   mdp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && step_has_rsp),
      .rsp_in     (step_rsp),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // no token once an error is latched
   a_no_tok_after_err: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.error_seen |-> !step_rsp.token_valid)
      else $error("token after error");

   // still waiting for '(' only at the first byte
   a_open_at_start: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_OPEN && !state_ff.error_seen |-> state_ff.byte_position == '0)
      else $error("open phase past offset 0");

   // a result with status set must be the final one
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[44] |-> rsp_tlast)
      else $error("status without done");

   // a final byte always restarts the parser
   a_restart: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == STATE_RESET)
      else $error("no restart after final byte");

endmodule

@@ dv/descriptor_token_checker.sv @@
// ----------------------------------------------------------------------------
// descriptor_token_checker
// Watches both streams of the method descriptor parser. Every accepted byte is
// run through a local model of the descriptor grammar; the token or done
// transaction it produces is queued and compared field by field with the
// oldest one when the parser emits a result.
// ----------------------------------------------------------------------------
module descriptor_token_checker
   import mdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tlast,  // last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,  // base_type, array_dims, token_start, token_length, status
   input  logic [1:0]  rsp_tuser,  // token_valid, token_is_return
   input  logic        rsp_tlast,  // done_res
   output int          fail_count,
   output int          pending,
   output int          checked_count,
   output int          token_count
);

   timeunit 1ns;
   timeprecision 1ps;

   mdp_rsp_type       expected_tokens[$];

   phase_type         ph;
   logic              in_obj;
   logic [DIMS_W-1:0] dims;
   logic [POS_W-1:0]  tbeg;
   logic [POS_W-1:0]  bpos;
   logic              err_flag;

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      token_count   = 0;
   end

   function automatic void clear_parse();
      ph       = PH_OPEN;
      in_obj   = 1'b0;
      dims     = '0;
      tbeg     = '0;
      bpos     = '0;
      err_flag = 1'b0;
   endfunction

   // {hit, base type} for the primitive type letters
   function automatic logic [BASE_W:0] primitive_code(input logic [7:0] b);
      case (b)
         CH_BYTE:   return {1'b1, BT_BYTE};
         CH_CHAR:   return {1'b1, BT_CHAR};
         CH_DOUBLE: return {1'b1, BT_DOUBLE};
         CH_FLOAT:  return {1'b1, BT_FLOAT};
         CH_INT:    return {1'b1, BT_INT};
         CH_LONG:   return {1'b1, BT_LONG};
         CH_SHORT:  return {1'b1, BT_SHORT};
         CH_BOOL:   return {1'b1, BT_BOOL};
         default:   return '0;
      endcase
   endfunction

   // Advances the grammar by one byte; returns 1 when a transaction is due.
   function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                     output mdp_rsp_type r);
      bit              bad;
      bit              tok;
      logic [BASE_W-1:0] base;
      logic [BASE_W:0] pc;
      bad  = 1'b0;
      tok  = 1'b0;
      base = '0;
      r    = '0;
      pc   = primitive_code(b);
      if (!err_flag) begin
         if (bpos >= MAX_LEN) begin
            bad = 1'b1;
         end else if (ph == PH_OPEN) begin
            if (b == CH_LPAREN) ph = PH_PARAMS;
            else bad = 1'b1;
         end else if (ph == PH_PARAMS || ph == PH_RET) begin
            if (in_obj) begin
               if (b == CH_NUL) begin
                  bad = 1'b1;
               end else if (b == CH_SEMI) begin
                  if (int'(bpos) == int'(tbeg) + int'(dims) + 1) begin
                     bad = 1'b1;
                  end else begin
                     tok  = 1'b1;
                     base = BT_OBJECT;
                  end
               end
            end else if (b == CH_RPAREN && ph == PH_PARAMS && dims == 0) begin
               ph = PH_RET;
            end else if (b == CH_VOID && ph == PH_RET && dims == 0) begin
               tbeg = bpos;
               tok  = 1'b1;
               base = BT_VOID;
            end else if (b == CH_ARRAY) begin
               if (dims >= MAX_DIMS) begin
                  bad = 1'b1;
               end else begin
                  if (dims == 0) tbeg = bpos;
                  dims = dims + 1'b1;
               end
            end else if (b == CH_OBJ) begin
               if (dims == 0) tbeg = bpos;
               in_obj = 1'b1;
            end else if (pc[BASE_W]) begin
               if (dims == 0) tbeg = bpos;
               tok  = 1'b1;
               base = pc[BASE_W-1:0];
            end else begin
               bad = 1'b1;
            end
         end else begin
            bad = 1'b1;
         end
      end
      if (bad) begin
         err_flag = 1'b1;
         tok      = 1'b0;
      end
      if (tok) begin
         r.token_valid     = 1'b1;
         r.token_is_return = (ph == PH_RET);
         r.base_type       = base;
         r.array_dims      = dims;
         r.token_start     = tbeg;
         r.token_length    = bpos - tbeg + 16'd1;
         if (ph == PH_RET) ph = PH_END;
         dims   = '0;
         in_obj = 1'b0;
      end
      if (bpos != 16'hFFFF) bpos = bpos + 1'b1;
      if (lst) begin
         r.done_res = 1'b1;
         r.status   = err_flag || (ph != PH_END);
         clear_parse();
      end
      return tok || lst;
   endfunction

   function automatic int field_mismatch(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v == act_v) return 0;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
   endfunction

   always @(posedge clock) begin
      mdp_rsp_type predicted;
      mdp_rsp_type seen;
      mdp_rsp_type want;
      int          bad_fields;
      if (reset) begin
         clear_parse();
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (parse_byte(req_tdata, req_tlast, predicted))
               expected_tokens.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.token_valid     = rsp_tuser[0];
            seen.token_is_return = rsp_tuser[1];
            seen.base_type       = rsp_tdata[3:0];
            seen.array_dims      = rsp_tdata[11:4];
            seen.token_start     = rsp_tdata[27:12];
            seen.token_length    = rsp_tdata[43:28];
            seen.status          = rsp_tdata[44];
            seen.done_res        = rsp_tlast;
            checked_count++;
            if (seen.token_valid) token_count++;
            if (expected_tokens.size() == 0) begin
               $error("result with nothing expected: tuser %b tdata %h tlast %b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               bad_fields = 0;
               bad_fields += field_mismatch("token_valid", want.token_valid,
                                            seen.token_valid);
               bad_fields += field_mismatch("token_is_return", want.token_is_return,
                                            seen.token_is_return);
               bad_fields += field_mismatch("base_type", want.base_type, seen.base_type);
               bad_fields += field_mismatch("array_dims", want.array_dims, seen.array_dims);
               bad_fields += field_mismatch("token_start", want.token_start,
                                            seen.token_start);
               bad_fields += field_mismatch("token_length", want.token_length,
                                            seen.token_length);
               bad_fields += field_mismatch("done_res", want.done_res, seen.done_res);
               bad_fields += field_mismatch("status", want.status, seen.status);
               if (bad_fields != 0) fail_count++;
            end
         end
      end
      pending <= expected_tokens.size();
   end

endmodule

@@ dv/method_descriptor_parser_tb.sv @@
// ----------------------------------------------------------------------------
// method_descriptor_parser_tb
// Streams method descriptors into the parser: a directed set covering several
// kinds of type and several malformed forms, maximum-depth descriptors on each
// side of the limit, then random well-formed, damaged and noise descriptors,
// with random gaps on the request side and random backpressure on the result
// side. Checking is done by descriptor_token_checker.
// ----------------------------------------------------------------------------
module method_descriptor_parser_tb
   import mdp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES  = 650;
   localparam int WATCHDOG_IDLE = 2000;
   localparam logic [7:0] PRIM_CHARS [8] = '{CH_BYTE, CH_CHAR, CH_DOUBLE, CH_FLOAT,
                                              CH_INT, CH_LONG, CH_SHORT, CH_BOOL};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending;
   int checked_count;
   int token_count;

   logic [7:0] desc_bytes[$];
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int ready_cycles = 0;
   int idle_cycles = 0;
   int desc_count = 0;
   int byte_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   method_descriptor_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   descriptor_token_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .token_count   (token_count)
   );

   // result-side backpressure; the stall profile is redrawn from four settings at regular intervals
   always @(negedge clock) begin
      ready_cycles++;
      if (ready_cycles % 400 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 15;
            2: stall_pct = 40;
            default: stall_pct = 70;
         endcase
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_IDLE) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("method_descriptor_parser_tb: FAIL");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) >= gap_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      byte_count++;
   endtask

   task automatic send_descriptor();
      for (int i = 0; i < desc_bytes.size(); i++)
         send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
      desc_count++;
   endtask

   // sender holds off until every expected result has been seen
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic void push_text(string s);
      foreach (s[i]) desc_bytes.push_back(s[i]);
   endfunction

   function automatic void push_field_type();
      int depth;
      int sel;
      int name_len;
      logic [7:0] c;
      sel = $urandom_range(0, 99);
      if (sel < 70) depth = 0;
      else if (sel < 95) depth = $urandom_range(1, 3);
      else depth = $urandom_range(4, 8);
      repeat (depth) desc_bytes.push_back(CH_ARRAY);
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
         desc_bytes.push_back(PRIM_CHARS[sel]);
      end else begin
         desc_bytes.push_back(CH_OBJ);
         name_len = $urandom_range(1, 6);
         repeat (name_len) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_SEMI);
            desc_bytes.push_back(c);
         end
         desc_bytes.push_back(CH_SEMI);
      end
   endfunction

   function automatic void build_well_formed();
      int params;
      desc_bytes.delete();
      desc_bytes.push_back(CH_LPAREN);
      params = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
      repeat (params) push_field_type();
      desc_bytes.push_back(CH_RPAREN);
      if ($urandom_range(0, 3) == 0) desc_bytes.push_back(CH_VOID);
      else push_field_type();
   endfunction

   function automatic void build_random_descriptor();
      int sel;
      int keep;
      sel = $urandom_range(0, 99);
      build_well_formed();
      if (sel >= 70 && sel < 80) begin
         desc_bytes[$urandom_range(0, desc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (sel >= 80 && sel < 87) begin
         keep = $urandom_range(1, desc_bytes.size() - 1);
         while (desc_bytes.size() > keep) void'(desc_bytes.pop_back());
      end else if (sel >= 87 && sel < 93) begin
         repeat ($urandom_range(1, 3)) desc_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (sel >= 93) begin
         desc_bytes.delete();
         if ($urandom_range(0, 1)) desc_bytes.push_back(CH_LPAREN);
         repeat ($urandom_range(1, 8)) desc_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_deep(int depth);
      desc_bytes.delete();
      desc_bytes.push_back(CH_LPAREN);
      repeat (depth) desc_bytes.push_back(CH_ARRAY);
      push_text("I)V");
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: byte, long, int, array, object and void types, then malformed forms
      desc_bytes.delete(); push_text("(B[[La;)V"); send_descriptor();
      desc_bytes.delete(); push_text("()J");       send_descriptor();
      desc_bytes.delete(); push_text("([)I");      send_descriptor();
      desc_bytes.delete(); push_text("()[");       send_descriptor();
      desc_bytes.delete(); push_text("(L;");       send_descriptor();
      desc_bytes.delete(); push_text("(V");        send_descriptor();
      desc_bytes.delete(); push_text("()VI");      send_descriptor();
      desc_bytes.delete(); desc_bytes.push_back(CH_LPAREN); desc_bytes.push_back(CH_NUL);
      send_descriptor();
      drain_results();

      // depth limit, each side of the boundary
      gap_pct = 5;
      build_deep(255);            send_descriptor();
      build_deep(256);            send_descriptor();
      drain_results();

      byte_count = 0;
      while (byte_count < RANDOM_BYTES) begin
         case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 10;
            2: gap_pct = 30;
            default: gap_pct = 60;
         endcase
         build_random_descriptor();
         send_descriptor();
         if ($urandom_range(0, 29) == 0) drain_results();
      end
      drain_results();
      repeat (20) @(posedge clock);

      $display("covered %0d descriptors: directed, 255/256-deep arrays,", desc_count);
      $display("random well-formed, damaged and noise input; %0d results, %0d type tokens",
               checked_count, token_count);
      if (fail_count == 0 && pending == 0) begin
         $display("method_descriptor_parser_tb: PASS");
      end else begin
         $display("method_descriptor_parser_tb: FAIL");
      end
      $finish;
   end

endmodule
